// ===== rtl/scpa_pkg.sv =====
package scpa_pkg;

  // polynomial coefficients
  localparam logic [17:0] SIN_K1 = 18'd205887;
  localparam logic [17:0] SIN_K3 = 18'd169336;
  localparam logic [17:0] SIN_K5 = 18'd167014;
  localparam logic [17:0] SIN_K7 = 18'd150000;
  localparam logic [17:0] COS_K2 = 18'd161704;
  localparam logic [17:0] COS_K4 = 18'd132996;
  localparam logic [17:0] COS_K6 = 18'd175016;
  localparam logic [17:0] COS_K8 = 18'd241700;

  // output limits
  localparam logic signed [20:0] OUT_MAX = 21'sd131071;
  localparam logic signed [20:0] OUT_MIN = -21'sd131072;

  // quadrant information carried down the pipeline
  typedef struct packed {
    logic q_hi;
    logic q_lo;
    logic quarter;
  } quad_t;

endpackage

// ===== rtl/sine_cosine_poly_approx.sv =====
// Sine and cosine of a phase given as a fraction of one turn.
// Input channel: in_valid / in_stall with in_phase, 20-bit unsigned, scaled
// by 2^20. A transaction is taken at a clock edge with in_valid high and
// in_stall low.
// Output channel: out_valid / out_stall with out_sine_out and out_cosine_out,
// 18-bit two's complement scaled by 2^17, saturated. One result transaction
// per input transaction, in order.
// Pipeline: 8 register stages. The depth is set by the chain of dependent
// 18x18 products (x^2, x^3/x^4, x^5/x^6/x^8, x^7), the coefficient products,
// the sum and the sign/saturation stage.
// Throughput: one transaction per cycle unless a shown result is held by
// out_stall; every stage holds one item.
// Reset (rst_n low, synchronous) clears all stage valid bits, so the pipe
// comes out empty.
// Stall: when out_stall is high while a result is shown, the whole pipe
// holds and in_stall goes high in the same cycle; nothing is dropped or
// repeated. When no result is shown the pipe keeps moving.
module sine_cosine_poly_approx
  import scpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_phase,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_sine_out,
  output logic signed [17:0] out_cosine_out
);

  logic adv;

  // valid bits, one per stage
  logic [7:0] vld_r;

  // stage 1: reflected offset
  logic [17:0] s1_x1_r;
  quad_t       s1_q_r;
  // stage 2: x^2
  logic [17:0] s2_x1_r, s2_x2_r;
  quad_t       s2_q_r;
  // stage 3: x^3, x^4
  logic [17:0] s3_x1_r, s3_x2_r, s3_x3_r, s3_x4_r;
  quad_t       s3_q_r;
  // stage 4: x^5, x^6, x^8
  logic [17:0] s4_x1_r, s4_x2_r, s4_x3_r, s4_x5_r, s4_x4_r, s4_x6_r, s4_x8_r;
  quad_t       s4_q_r;
  // stage 5: x^7
  logic [17:0] s5_x1_r, s5_x2_r, s5_x3_r, s5_x4_r, s5_x5_r, s5_x6_r, s5_x7_r;
  logic [17:0] s5_x8_r;
  quad_t       s5_q_r;
  // stage 6: coefficient terms
  logic [18:0] s6_t1_r, s6_c2_r;
  logic [17:0] s6_t3_r;
  logic [14:0] s6_t5_r;
  logic [10:0] s6_t7_r;
  logic [16:0] s6_c4_r;
  logic [12:0] s6_c6_r;
  logic [7:0]  s6_c8_r;
  quad_t       s6_q_r;
  // stage 7: halved sums
  logic signed [19:0] s7_s_r, s7_c_r;
  quad_t              s7_q_r;
  // stage 8: output registers
  logic signed [17:0] sin_r, cos_r;

  // pipe moves unless a shown result is held
  assign adv      = !(vld_r[7] && out_stall);
  assign in_stall = !adv;

  // stage 1 input logic
  logic [17:0] x1_nxt;
  quad_t       q_nxt;
  always_comb begin
    x1_nxt = in_phase[18] ? (18'd0 - in_phase[17:0]) : in_phase[17:0];
    q_nxt.q_hi    = in_phase[19];
    q_nxt.q_lo    = in_phase[18];
    q_nxt.quarter = in_phase[18] && (in_phase[17:0] == 18'd0);
  end

  // power products
  logic [35:0] p_x2, p_x3, p_x4, p_x5, p_x6, p_x8, p_x7;
  assign p_x2 = 36'(s1_x1_r) * 36'(s1_x1_r);
  assign p_x3 = 36'(s2_x2_r) * 36'(s2_x1_r);
  assign p_x4 = 36'(s2_x2_r) * 36'(s2_x2_r);
  assign p_x5 = 36'(s3_x2_r) * 36'(s3_x3_r);
  assign p_x6 = 36'(s3_x4_r) * 36'(s3_x2_r);
  assign p_x8 = 36'(s3_x4_r) * 36'(s3_x4_r);
  assign p_x7 = 36'(s4_x2_r) * 36'(s4_x5_r);

  // coefficient products
  logic [35:0] m_t1, m_t3, m_t5, m_t7, m_c2, m_c4, m_c6, m_c8;
  assign m_t1 = 36'(SIN_K1) * 36'(s5_x1_r);
  assign m_t3 = 36'(SIN_K3) * 36'(s5_x3_r);
  assign m_t5 = 36'(SIN_K5) * 36'(s5_x5_r);
  assign m_t7 = 36'(SIN_K7) * 36'(s5_x7_r);
  assign m_c2 = 36'(COS_K2) * 36'(s5_x2_r);
  assign m_c4 = 36'(COS_K4) * 36'(s5_x4_r);
  assign m_c6 = 36'(COS_K6) * 36'(s5_x6_r);
  assign m_c8 = 36'(COS_K8) * 36'(s5_x8_r);

  // polynomial sums and floor halving
  logic signed [20:0] s_sum, c_sum;
  always_comb begin
    s_sum = $signed({2'b00, s6_t1_r}) - $signed({3'b000, s6_t3_r})
          + $signed({6'd0, s6_t5_r}) - $signed({10'd0, s6_t7_r});
    c_sum = 21'sd262144 - $signed({2'b00, s6_c2_r})
          + $signed({4'd0, s6_c4_r}) - $signed({8'd0, s6_c6_r})
          + $signed({13'd0, s6_c8_r});
  end

  // quarter-turn fix, sign by quadrant, saturation
  logic signed [20:0] s_mag, c_mag, s_sgn, c_sgn;
  logic signed [17:0] sin_nxt, cos_nxt;
  always_comb begin
    s_mag = s7_q_r.quarter ? 21'sd131072 : 21'(s7_s_r);
    c_mag = s7_q_r.quarter ? 21'sd0 : 21'(s7_c_r);
    s_sgn = s7_q_r.q_hi ? -s_mag : s_mag;
    c_sgn = (s7_q_r.q_hi ^ s7_q_r.q_lo) ? -c_mag : c_mag;
    priority if (s_sgn > OUT_MAX) begin
      sin_nxt = 18'(OUT_MAX);
    end else if (s_sgn < OUT_MIN) begin
      sin_nxt = 18'(OUT_MIN);
    end else begin
      sin_nxt = s_sgn[17:0];
    end
    priority if (c_sgn > OUT_MAX) begin
      cos_nxt = 18'(OUT_MAX);
    end else if (c_sgn < OUT_MIN) begin
      cos_nxt = 18'(OUT_MIN);
    end else begin
      cos_nxt = c_sgn[17:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[6:0], in_valid};
    end
  end

  // data path registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x1_r <= x1_nxt;
      s1_q_r  <= q_nxt;

      s2_x1_r <= s1_x1_r;
      s2_x2_r <= p_x2[35:18];
      s2_q_r  <= s1_q_r;

      s3_x1_r <= s2_x1_r;
      s3_x2_r <= s2_x2_r;
      s3_x3_r <= p_x3[35:18];
      s3_x4_r <= p_x4[35:18];
      s3_q_r  <= s2_q_r;

      s4_x1_r <= s3_x1_r;
      s4_x2_r <= s3_x2_r;
      s4_x3_r <= s3_x3_r;
      s4_x4_r <= s3_x4_r;
      s4_x5_r <= p_x5[35:18];
      s4_x6_r <= p_x6[35:18];
      s4_x8_r <= p_x8[35:18];
      s4_q_r  <= s3_q_r;

      s5_x1_r <= s4_x1_r;
      s5_x2_r <= s4_x2_r;
      s5_x3_r <= s4_x3_r;
      s5_x4_r <= s4_x4_r;
      s5_x5_r <= s4_x5_r;
      s5_x6_r <= s4_x6_r;
      s5_x8_r <= s4_x8_r;
      s5_x7_r <= p_x7[35:18];
      s5_q_r  <= s4_q_r;

      s6_t1_r <= m_t1[35:17];
      s6_t3_r <= m_t3[35:18];
      s6_t5_r <= m_t5[35:21];
      s6_t7_r <= m_t7[35:25];
      s6_c2_r <= m_c2[35:17];
      s6_c4_r <= m_c4[35:19];
      s6_c6_r <= m_c6[35:23];
      s6_c8_r <= m_c8[35:28];
      s6_q_r  <= s5_q_r;

      s7_s_r <= 20'(s_sum >>> 1);
      s7_c_r <= 20'(c_sum >>> 1);
      s7_q_r <= s6_q_r;

      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign out_valid      = vld_r[7];
  assign out_sine_out   = sin_r;
  assign out_cosine_out = cos_r;

endmodule

// ===== rtl/scpa_checker.sv =====
module scpa_checker
  import scpa_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [19:0]        in_phase,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [17:0] out_sine_out,
  input logic signed [17:0] out_cosine_out
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sine_out)
      && $stable(out_cosine_out))
    else $error("result changed while stalled");

  // input is only throttled by a held result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // an input transaction that passes every stage unstalled reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall ##1 !in_stall [*7] |=> out_valid)
    else $error("result missing after an unstalled pass through the pipe");

endmodule

bind sine_cosine_poly_approx scpa_checker u_scpa_checker (.*);
